### rtl/core/pfa_pkg.sv
// Shared types and constants of the page frame allocator.
// Holds the token and grant formats that travel along the frame cell chain.
// No dependencies.
package pfa_pkg;

	// Table geometry
	localparam int FRAMES    = 64;
	localparam int FRAME_W   = $clog2(FRAMES);
	localparam int CNT_W     = $clog2(FRAMES + 1);
	localparam int BURST_MAX = 64;
	localparam int NEED_W    = $clog2(BURST_MAX + 1);
	localparam int LP_W      = 6;

	// Configuration register indexes
	localparam logic [1:0] REG_PAGE_SHIFT    = 2'd0;
	localparam logic [1:0] REG_FRAMES_IN_USE = 2'd1;

	// Result status codes
	typedef enum logic [2:0] {
		ST_GRANTED  = 3'd0,
		ST_TOO_BIG  = 3'd1,
		ST_NO_FREE  = 3'd2,
		ST_ZERO     = 3'd3,
		ST_RELEASED = 3'd4
	} status_t;

	// Pass that a token performs as it walks the chain
	typedef enum logic [1:0] {
		OP_COUNT   = 2'd0,
		OP_GRANT   = 2'd1,
		OP_RELEASE = 2'd2
	} op_t;

	// Token handed from cell to cell
	typedef struct packed {
		logic              vld;
		op_t               op;
		logic [7:0]        pid;
		logic [NEED_W-1:0] need;
		logic [NEED_W-1:0] got;
		logic [CNT_W-1:0]  cnt;
		logic [FRAME_W-1:0] pos;
	} tok_t;

	// Frame grant raised by the cell that holds the token
	typedef struct packed {
		logic               vld;
		logic [FRAME_W-1:0] frame;
		logic [LP_W-1:0]    lp;
		logic               last;
	} grant_t;

	// Broadcast control from the sequencer to every cell
	typedef struct packed {
		logic             adv;
		logic [CNT_W-1:0] active;
	} chain_ctl_t;

endpackage

### rtl/core/page_frame_allocator_unit.sv
// Page frame allocator: sequencer, config registers, result register, cell chain.
// Release runs one chain pass; allocate a count pass, then a grant pass when it fits, only
// the count pass when too few frames are free, none for zero or oversized requests. Each pass
// walks one token through the 64-cell chain, one cell per cycle; a stalled result freezes the
// chain while a grant is pending. One request at a time. Reset (arst_n low) frees all frames,
// sets page_shift to 4 and frames_in_use to 64; owner and logical fields are not cleared.
module page_frame_allocator_unit
	import pfa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	// request channel
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        mode,
	input  logic [15:0] words,
	input  logic [7:0]  pid,
	// result channel
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [2:0]  status,
	output logic [5:0]  frame,
	output logic [5:0]  logical_page,
	output logic [6:0]  freed_count,
	output logic        last
);

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_COUNT   = 5'b00010,
		S_GRANT   = 5'b00100,
		S_RELEASE = 5'b01000,
		S_RESULT  = 5'b10000
	} state_t;

	state_t      state_q, state_nxt;
	logic [3:0]  page_shift_q;
	logic [6:0]  frames_q;
	status_t     res_status_q, res_status_nxt;
	logic [CNT_W-1:0] res_freed_q, res_freed_nxt;
	logic        launch_vld_q;
	tok_t        launch_pl_q, launch_pl_nxt;
	logic        launch_now;
	logic        rsp_valid_q;
	status_t     rsp_status_q;
	logic [5:0]  rsp_frame_q;
	logic [5:0]  rsp_lp_q;
	logic [6:0]  rsp_freed_q;
	logic        rsp_last_q;

	chain_ctl_t  ctl;
	tok_t        head_tok;
	tok_t        end_tok;
	grant_t      grant;
	logic        out_free;
	logic        req_xfer;
	logic [31:0] pages;
	logic [31:0] total_words;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_shift_q <= 4'd4;
			frames_q     <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_PAGE_SHIFT) page_shift_q <= cfg_data[3:0];
			else if (cfg_index == REG_FRAMES_IN_USE) frames_q <= cfg_data;
		end
	end

	// Chain control: freeze while a grant cannot be taken
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign ctl.adv    = !grant.vld || out_free;
	assign ctl.active = CNT_W'((32'(frames_q) > FRAMES) ? FRAMES : 32'(frames_q));

	assign req_stall = (state_q != S_IDLE);
	assign req_xfer  = req_valid && !req_stall;

	// Page count and memory size of the request
	assign pages = (32'(words) + ((32'd1 << page_shift_q) - 32'd1)) >> page_shift_q;
	assign total_words = 32'(ctl.active) << page_shift_q;

	// Sequencer
	always_comb begin
		state_nxt      = state_q;
		res_status_nxt = res_status_q;
		res_freed_nxt  = res_freed_q;
		launch_now     = 1'b0;
		launch_pl_nxt  = '0;
		priority case (1'b1)
			state_q[0]: begin
				if (req_xfer) begin
					launch_pl_nxt.pid = pid;
					if (mode) begin
						launch_now         = 1'b1;
						launch_pl_nxt.op   = OP_RELEASE;
						state_nxt          = S_RELEASE;
					end else if (words == 16'd0) begin
						res_status_nxt = ST_ZERO;
						state_nxt      = S_RESULT;
					end else if (32'(words) > total_words || pages > BURST_MAX) begin
						res_status_nxt = ST_TOO_BIG;
						state_nxt      = S_RESULT;
					end else begin
						launch_now         = 1'b1;
						launch_pl_nxt.op   = OP_COUNT;
						launch_pl_nxt.need = NEED_W'(pages);
						state_nxt          = S_COUNT;
					end
				end
			end
			state_q[1]: begin
				if (end_tok.vld) begin
					if (32'(end_tok.cnt) < 32'(end_tok.need)) begin
						res_status_nxt = ST_NO_FREE;
						state_nxt      = S_RESULT;
					end else begin
						launch_now         = 1'b1;
						launch_pl_nxt.op   = OP_GRANT;
						launch_pl_nxt.pid  = end_tok.pid;
						launch_pl_nxt.need = end_tok.need;
						state_nxt          = S_GRANT;
					end
				end
			end
			state_q[2]: begin
				if (end_tok.vld) state_nxt = S_IDLE;
			end
			state_q[3]: begin
				if (end_tok.vld) begin
					res_status_nxt = ST_RELEASED;
					res_freed_nxt  = end_tok.cnt;
					state_nxt      = S_RESULT;
				end
			end
			state_q[4]: begin
				if (out_free && !grant.vld) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			launch_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.adv) launch_vld_q <= launch_now;
		end
	end

	// Hold the single-result payload and the launched token
	always_ff @(posedge clk) begin
		res_status_q <= res_status_nxt;
		res_freed_q  <= (state_q == S_IDLE) ? '0 : res_freed_nxt;
		if (ctl.adv) launch_pl_q <= launch_pl_nxt;
	end

	always_comb begin
		head_tok     = launch_pl_q;
		head_tok.vld = launch_vld_q;
	end

	pfa_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.tok_i   (head_tok),
		.tok_o   (end_tok),
		.grant_o (grant)
	);

	// Result register: load a grant or a single status result, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= grant.vld || (state_q == S_RESULT);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (grant.vld) begin
				rsp_status_q <= ST_GRANTED;
				rsp_frame_q  <= 6'(grant.frame);
				rsp_lp_q     <= grant.lp;
				rsp_freed_q  <= '0;
				rsp_last_q   <= grant.last;
			end else begin
				rsp_status_q <= res_status_q;
				rsp_frame_q  <= '0;
				rsp_lp_q     <= '0;
				rsp_freed_q  <= 7'(res_freed_q);
				rsp_last_q   <= 1'b1;
			end
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = rsp_status_q;
	assign frame        = rsp_frame_q;
	assign logical_page = rsp_lp_q;
	assign freed_count  = rsp_freed_q;
	assign last         = rsp_last_q;

`ifndef NO_ASSERTIONS
	a_grant_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		grant.vld |-> state_q == S_GRANT)
		else $error("frame granted outside the grant pass");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |=> state_q != S_IDLE)
		else $error("request accepted without leaving idle");

	a_launch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		launch_vld_q |-> (state_q == S_COUNT || state_q == S_GRANT ||
		                  state_q == S_RELEASE))
		else $error("token launched with no pass in progress");
`endif

endmodule

### rtl/core/pfa_cell.sv
// One frame table entry: used bit, owner and logical page.
// Processes the token passing through it and forwards it to the next cell.
// Depends on pfa_pkg.
module pfa_cell
	import pfa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  chain_ctl_t ctl,
	input  tok_t       tok_i,
	output tok_t       tok_o,
	output grant_t     grant_o
);

	logic            used_q;
	logic [7:0]      owner_q;
	logic [LP_W-1:0] logical_q;
	logic            tok_vld_q;
	tok_t            tok_pl_q;

	logic hit_free;
	logic owned;
	logic take;
	tok_t tok_nxt;

	// Evaluate this frame against the passing token
	always_comb begin
		hit_free = !used_q && (CNT_W'(tok_i.pos) < ctl.active);
		owned    = used_q && (owner_q == tok_i.pid);
		take     = tok_i.vld && (tok_i.op == OP_GRANT) && hit_free &&
		           (tok_i.got < tok_i.need);
		tok_nxt     = tok_i;
		tok_nxt.pos = tok_i.pos + 1'b1;
		unique case (tok_i.op)
			OP_COUNT: begin
				if (hit_free) tok_nxt.cnt = tok_i.cnt + 1'b1;
			end
			OP_RELEASE: begin
				if (owned) tok_nxt.cnt = tok_i.cnt + 1'b1;
			end
			OP_GRANT: begin
				if (take) tok_nxt.got = tok_i.got + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Raise a grant for this frame
	always_comb begin
		grant_o.vld   = take;
		grant_o.frame = tok_i.pos;
		grant_o.lp    = tok_i.got[LP_W-1:0];
		grant_o.last  = ((tok_i.got + NEED_W'(1)) == tok_i.need);
	end

	// Update the used bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (ctl.adv && tok_i.vld) begin
			if (tok_i.op == OP_RELEASE && owned) used_q <= 1'b0;
			else if (take) used_q <= 1'b1;
		end
	end

	// Record owner and logical page on a grant
	always_ff @(posedge clk) begin
		if (ctl.adv && take) begin
			owner_q   <= tok_i.pid;
			logical_q <= tok_i.got[LP_W-1:0];
		end
	end

	// Advance the token to the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else if (ctl.adv) begin
			tok_vld_q <= tok_i.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) tok_pl_q <= tok_nxt;
	end

	always_comb begin
		tok_o     = tok_pl_q;
		tok_o.vld = tok_vld_q;
	end

endmodule

### rtl/core/pfa_chain.sv
// Row of frame cells linked head to tail, with the grant collector.
// Depends on pfa_pkg and pfa_cell.
module pfa_chain
	import pfa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  chain_ctl_t ctl,
	input  tok_t       tok_i,
	output tok_t       tok_o,
	output grant_t     grant_o
);

	tok_t   link [FRAMES+1];
	grant_t grant_w [FRAMES];
	logic [FRAMES-1:0] tok_vlds;
	logic [FRAMES-1:0] grant_vlds;

	assign link[0] = tok_i;

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		pfa_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.tok_i   (link[i]),
			.tok_o   (link[i+1]),
			.grant_o (grant_w[i])
		);
		assign tok_vlds[i]   = link[i+1].vld;
		assign grant_vlds[i] = grant_w[i].vld;
	end

	assign tok_o = link[FRAMES];

	// Select the granting cell; at most one cell holds the token
	always_comb begin
		grant_o = '0;
		for (int i = 0; i < FRAMES; i++) begin
			if (grant_w[i].vld) grant_o = grant_w[i];
		end
	end

`ifndef NO_ASSERTIONS
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vlds))
		else $error("more than one token in the cell chain");

	a_one_grant: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(grant_vlds))
		else $error("more than one cell granting at once");

	a_grant_hold: assert property (@(posedge clk) disable iff (!arst_n)
		grant_o.vld && !ctl.adv |=> grant_o.vld && $stable(grant_o.frame))
		else $error("pending grant lost while chain was frozen");
`endif

endmodule
